@@ rtl/afe_pkg.sv @@
// afe_pkg: request codes, constants and controller/datapath link types
// for the linear fade envelope; no dependencies
package afe_pkg;

  localparam int FADE_SECONDS = 3;
  localparam int BASE_RATE    = 11025;

  localparam int SAMPLE_W = 16;
  localparam int LEN_W    = 18;
  localparam int COUNT_W  = LEN_W + 1;
  localparam int PROD_W   = SAMPLE_W + COUNT_W;
  localparam int STEP_W   = $clog2(PROD_W);

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(FADE_SECONDS * BASE_RATE);

  // request codes
  typedef enum logic [2:0] {
    REQ_SAMPLE    = 3'd0,
    REQ_START     = 3'd1,
    REQ_FADE_DOWN = 3'd2,
    REQ_FADE_UP   = 3'd3,
    REQ_STOP      = 3'd4
  } req_code_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_WRITE
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic take;      // request accepted this cycle
    logic load_div;  // multiply and load the divider
    logic div_step;  // one quotient bit
    logic emit;      // write the output register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_out;  // pending request yields a result
    logic need_div;  // that result goes through the divider
    logic out_free;  // output register can take a result
  } dp_sts_t;

endpackage

@@ rtl/afe_if.sv @@
// afe_if: request and result channel interfaces for the fade envelope
// depends on nothing
interface afe_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic signed [15:0] sample_in;

  modport source (output valid, req_type, sample_in, input ready);
  modport sink   (input valid, req_type, sample_in, output ready);
endinterface

interface afe_res_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_out;
  logic               fade_done;

  modport source (output valid, sample_out, fade_done, input ready);
  modport sink   (input valid, sample_out, fade_done, output ready);
endinterface

@@ rtl/afe_ctrl.sv @@
// afe_ctrl: sequencing state machine and divide step counter
// depends on afe_pkg
module afe_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  afe_pkg::dp_sts_t sts,
  output afe_pkg::dp_cmd_t cmd
);
  import afe_pkg::*;

  ctrl_state_t       state, state_next;
  logic [STEP_W-1:0] step, step_next;

  // state and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next   = state;
    step_next    = step;
    cmd          = '0;
    req_ready    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.take = 1'b1;
          if (sts.need_div) state_next = ST_MUL;
          else if (sts.need_out) state_next = ST_WRITE;
        end
      end
      ST_MUL: begin
        cmd.load_div = 1'b1;
        step_next    = '0;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        step_next    = step + 1'b1;
        if (step == STEP_W'(PROD_W - 1)) state_next = ST_WRITE;
      end
      ST_WRITE: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

@@ rtl/afe_dp.sv @@
// afe_dp: fade state, length register, multiplier, serial divider and
// output register; depends on afe_pkg and afe_if
module afe_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [afe_pkg::LEN_W-1:0]   cfg_wr_data,
  afe_req_if.sink                     req,
  afe_res_if.source                   res,
  input  afe_pkg::dp_cmd_t            cmd,
  output afe_pkg::dp_sts_t            sts
);
  import afe_pkg::*;

  logic [LEN_W-1:0]          fade_len;
  logic signed [COUNT_W-1:0] fade_count, fade_count_next;
  logic                      playing, playing_next;

  logic signed [COUNT_W-1:0] cnt_dec;
  logic [COUNT_W-1:0]        mag;
  logic                      cnt_pos, cnt_neg, cnt_zero;
  logic                      done_now;

  logic signed [SAMPLE_W-1:0] s_reg;
  logic [COUNT_W-1:0]         mag_reg;
  logic [LEN_W-1:0]           dvs;
  logic                       pass_reg, done_reg;
  logic [SAMPLE_W-1:0]        abs_s;

  logic [PROD_W-1:0]  dq;
  logic [LEN_W-1:0]   rem;
  logic [LEN_W:0]     rem_sh;
  logic               q_bit;
  logic [SAMPLE_W-1:0] sat_out;

  function automatic logic [SAMPLE_W-1:0] req_abs(input logic signed [SAMPLE_W-1:0] v);
    req_abs = v[SAMPLE_W-1] ? SAMPLE_W'(-v) : SAMPLE_W'(v);
  endfunction

  // counter decode
  assign cnt_zero = (fade_count == '0);
  assign cnt_neg  = fade_count[COUNT_W-1];
  assign cnt_pos  = !cnt_neg && !cnt_zero;
  assign cnt_dec  = fade_count - COUNT_W'(1);
  assign mag      = cnt_pos ? COUNT_W'(cnt_dec) : COUNT_W'(-cnt_dec);

  assign sts.need_out = (req.req_type == REQ_SAMPLE) && playing;
  assign sts.need_div = (req.req_type == REQ_SAMPLE) && playing && !cnt_zero;
  assign sts.out_free = !res.valid || res.ready;

  // next fade state for the pending request
  always_comb begin
    fade_count_next = fade_count;
    playing_next    = playing;
    done_now        = 1'b0;
    unique case (req.req_type)
      REQ_SAMPLE: begin
        if (playing && cnt_pos) begin
          fade_count_next = cnt_dec;
          if (cnt_dec == '0) begin
            playing_next = 1'b0;
            done_now     = 1'b1;
          end
        end else if (playing && cnt_neg) begin
          if (mag >= {1'b0, fade_len}) fade_count_next = '0;
          else fade_count_next = cnt_dec;
        end
      end
      REQ_START: begin
        playing_next    = 1'b1;
        fade_count_next = -COUNT_W'(1);
      end
      REQ_FADE_DOWN: begin
        if (playing && cnt_neg) fade_count_next = -fade_count;
        else if (playing && cnt_zero) fade_count_next = COUNT_W'(fade_len);
      end
      REQ_FADE_UP: begin
        if (playing && cnt_pos) fade_count_next = -fade_count;
        else if (playing && cnt_zero) fade_count_next = -COUNT_W'(1);
      end
      REQ_STOP: begin
        playing_next    = 1'b0;
        fade_count_next = '0;
      end
      default: ;
    endcase
  end

  // control state and length register
  always_ff @(posedge clk) begin
    if (rst) begin
      fade_len    <= LEN_RESET;
      fade_count  <= '0;
      playing     <= 1'b0;
    end else begin
      if (cfg_wr_en) fade_len <= cfg_wr_data;
      if (cmd.take) begin
        fade_count <= fade_count_next;
        playing    <= playing_next;
      end
    end
  end

  // operand capture on accept
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      s_reg    <= req.sample_in;
      mag_reg  <= mag;
      pass_reg <= cnt_zero;
      done_reg <= done_now;
      dvs      <= (fade_len == '0) ? LEN_W'(1) : fade_len;
    end
  end

  assign abs_s = req_abs(s_reg);

  // restoring divider, one quotient bit per cycle
  assign rem_sh = {rem, dq[PROD_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (cmd.load_div) begin
      dq  <= PROD_W'(abs_s) * mag_reg;
      rem <= '0;
    end else if (cmd.div_step) begin
      dq  <= {dq[PROD_W-2:0], q_bit};
      rem <= q_bit ? LEN_W'(rem_sh - {1'b0, dvs}) : LEN_W'(rem_sh);
    end
  end

  // sign restore and saturation of the quotient
  always_comb begin
    if (s_reg[SAMPLE_W-1]) begin
      if (dq > PROD_W'(32768)) sat_out = 16'h8000;
      else sat_out = SAMPLE_W'(-dq[SAMPLE_W-1:0]);
    end else begin
      if (dq > PROD_W'(32767)) sat_out = 16'h7FFF;
      else sat_out = dq[SAMPLE_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (cmd.emit) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res.sample_out <= pass_reg ? s_reg : $signed(sat_out);
      res.fade_done  <= done_reg;
    end
  end

endmodule

@@ rtl/audio_linear_fade_envelope.sv @@
// audio_linear_fade_envelope: top level of the linear fade envelope
// depends on afe_pkg, afe_if, afe_ctrl and afe_dp
//
// Usage
//   req carries one request per handshake: a sample, start with fade-up,
//   fade down, fade up or stop. res carries one faded sample for each
//   sample request made while playing; other requests give no result.
//   cfg_wr_en / cfg_wr_data write the fade length in samples; write it
//   only while the block is idle.
// Sequencing
//   Commands are taken while idle and leave the block idle. A sample
//   with no fade skips the multiply and divider. A faded sample passes
//   accept, one 16x19 multiply, 35 steps of the restoring divider (one
//   quotient bit per cycle over the 35-bit product) and the output write.
//   Requests wait for that write, so the divider sets the sample rate.
// Reset
//   rst is synchronous: fade length 33075, stopped, no fade, output empty.
// Stall
//   A result waiting on res is held. Requests are still taken while it
//   waits; a new result waits in the block until the register frees.
module audio_linear_fade_envelope (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [afe_pkg::LEN_W-1:0] cfg_wr_data,
  afe_req_if.sink                   req,
  afe_res_if.source                 res
);
  import afe_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  afe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  afe_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req),
    .res         (res),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

@@ rtl/afe_checker.sv @@
// afe_checker: port-level checks on the fade envelope, bound to the top
// depends on audio_linear_fade_envelope
module afe_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [15:0] res_sample_out,
  input logic        res_fade_done
);

  // stalled result stays offered
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  // stalled result payload holds
  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(res_sample_out) && $stable(res_fade_done))
    else $error("result payload changed while stalled");

  // the block only goes busy after taking a request
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    $fell(req_ready) |-> $past(req_valid))
    else $error("ready dropped with no request taken");

  // a new result is only written from the busy write phase
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(!req_ready))
    else $error("result appeared while idle");

endmodule

bind audio_linear_fade_envelope afe_checker u_afe_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .res_sample_out (res.sample_out),
  .res_fade_done  (res.fade_done)
);
